// File: design/hbe_pkg.sv
package hbe_pkg;

  localparam int BIN_SLOTS     = 1024;
  localparam int FRACTION_BITS = 24;
  localparam int BIN_AW        = $clog2(BIN_SLOTS);

  localparam int CNT_W   = 40;
  localparam int VAL_W   = 32;
  localparam int REQ_W   = 11;
  localparam int IDX_W   = 10;
  localparam int PROB_W  = 25;
  localparam int CFG_AW  = 3;

  // shared divider: widest dividend is a count scaled by the fraction
  localparam int DIV_N   = CNT_W + FRACTION_BITS;
  localparam int DVS_W   = CNT_W;

  localparam logic [CNT_W-1:0] CNT_MAX     = {CNT_W{1'b1}};
  localparam logic [VAL_W-1:0] WIDTH_LARGE = {VAL_W{1'b1}};

  typedef enum logic [1:0] {
    FUNC_CLEAR = 2'd0,
    FUNC_ADD   = 2'd1,
    FUNC_READ  = 2'd2,
    FUNC_NONE  = 2'd3
  } func_t;

  typedef enum logic [CFG_AW-1:0] {
    REG_SAMPLE_MIN  = 3'd0,
    REG_SAMPLE_MAX  = 3'd1,
    REG_BIN_REQUEST = 3'd2,
    REG_USE_EXPL    = 3'd3,
    REG_EXPL_ORIGIN = 3'd4,
    REG_EXPL_WIDTH  = 3'd5
  } reg_idx_t;

  typedef struct packed {
    logic             start;
    logic [DIV_N-1:0] dividend;
    logic [DVS_W-1:0] divisor;
  } div_req_t;

  typedef struct packed {
    logic             done;
    logic [DIV_N-1:0] quotient;
  } div_rsp_t;

endpackage

// File: design/binned_histogram_engine.sv
// Binned histogram engine. Words on the input stream carry an operation in
// s_tuser: clear (fix origin and width, zero all bins and the total), add
// (weighted sample into bin (value-origin)/width, clamped to the store, bins
// and total saturating at 2^40-1) or read (bin count and count/total as an
// unsigned 1.24 fraction; no_samples in m_tuser flags an empty histogram).
// One word is worked on at a time. After reset and after every clear the
// block sweeps the 1024-entry bin memory, one entry a cycle, and takes no
// word during the sweep. Bin widths, bin indexes and fractions come from
// one shared bit-serial divider of 64 steps. An add of a sample below the
// origin skips the divide; a read of an empty histogram skips the divide
// and one for an index past the store also skips the memory read, and the
// result may wait on m_tready; a derived clear runs its divide before the
// sweep. The read-modify-write of a bin goes through the single-port-read
// memory (registered read) in two steps.
module binned_histogram_engine (
  input  logic        clk,
  input  logic        rst,
  // configuration writes
  input  logic        cfg_we,
  input  logic [2:0]  cfg_index,
  input  logic [31:0] cfg_data,
  // input words
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [79:0] s_tdata,   // sample_value[31:0], sample_weight[63:32],
                                 // read_index[73:64], zero pad
  input  logic [1:0]  s_tuser,   // func[1:0]
  // result words
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [79:0] m_tdata,   // bin_number[9:0], bin_total[49:10],
                                 // probability[74:50], zero pad
  output logic        m_tuser    // no_samples[0]
);
  import hbe_pkg::*;

  typedef enum logic [3:0] {
    ST_CLR, ST_IDLE, ST_SET_DIV, ST_ADD_DIV, ST_ADD_RD, ST_ADD_WR,
    ST_RD_RD, ST_RD_CNT, ST_RD_DIV, ST_RD_OUT
  } state_t;

  state_t state;

  // config registers
  logic signed [VAL_W-1:0] sample_min, sample_max, explicit_origin;
  logic [REQ_W-1:0]        bin_request;
  logic                    use_explicit;
  logic [VAL_W-1:0]        explicit_width;

  // active bins and running total
  logic signed [VAL_W-1:0] active_origin;
  logic [VAL_W-1:0]        active_width;
  logic [CNT_W-1:0]        weight_sum;

  // per-word working registers
  logic [BIN_AW-1:0] bin, clr_addr;
  logic [VAL_W-1:0]  weight;
  logic [IDX_W-1:0]  rd_idx;
  logic [CNT_W-1:0]  count;

  logic [BIN_AW-1:0] ram_raddr, ram_waddr;
  logic              ram_we;
  logic [CNT_W-1:0]  ram_wdata, ram_rdata;

  div_req_t div_req;
  div_rsp_t div_rsp;

  // decoded input word
  func_t                   in_func;
  logic signed [VAL_W-1:0] in_value;
  logic [VAL_W-1:0]        in_weight;
  logic [IDX_W-1:0]        in_index;
  logic signed [VAL_W:0]   offset, span;
  logic                    idx_in_store;
  logic [CNT_W:0]          bin_sum, tot_sum;
  logic [REQ_W-1:0]        req_eff;

  assign in_func   = func_t'(s_tuser);
  assign in_value  = s_tdata[31:0];
  assign in_weight = s_tdata[63:32];
  assign in_index  = s_tdata[73:64];

  assign offset  = {in_value[VAL_W-1], in_value} - {active_origin[VAL_W-1], active_origin};
  assign span    = {sample_max[VAL_W-1], sample_max} - {sample_min[VAL_W-1], sample_min};
  assign req_eff = (bin_request == '0) ? REQ_W'(1) : bin_request;
  assign idx_in_store = {{(32-IDX_W){1'b0}}, in_index} < 32'(BIN_SLOTS);

  assign bin_sum = {1'b0, ram_rdata} + {{(CNT_W-VAL_W+1){1'b0}}, weight};
  assign tot_sum = {1'b0, weight_sum} + {{(CNT_W-VAL_W+1){1'b0}}, weight};

  assign s_tready = (state == ST_IDLE);

  // memory port steering
  always_comb begin
    ram_raddr = bin;
    ram_we    = 1'b0;
    ram_waddr = bin;
    ram_wdata = bin_sum[CNT_W] ? CNT_MAX : bin_sum[CNT_W-1:0];
    if (state == ST_CLR) begin
      ram_we    = 1'b1;
      ram_waddr = clr_addr;
      ram_wdata = '0;
    end else if (state == ST_ADD_WR) begin
      ram_we = 1'b1;
    end
  end

  hbe_ram #(.DEPTH(BIN_SLOTS), .WIDTH(CNT_W)) u_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  hbe_div u_div (
    .clk (clk),
    .rst (rst),
    .req (div_req),
    .rsp (div_rsp)
  );

  // config port
  always_ff @(posedge clk) begin
    if (rst) begin
      sample_min      <= '0;
      sample_max      <= '0;
      bin_request     <= REQ_W'(1);
      use_explicit    <= 1'b0;
      explicit_origin <= '0;
      explicit_width  <= VAL_W'(1);
    end else if (cfg_we) begin
      case (reg_idx_t'(cfg_index))
        REG_SAMPLE_MIN:  sample_min      <= cfg_data;
        REG_SAMPLE_MAX:  sample_max      <= cfg_data;
        REG_BIN_REQUEST: bin_request     <= cfg_data[REQ_W-1:0];
        REG_USE_EXPL:    use_explicit    <= cfg_data[0];
        REG_EXPL_ORIGIN: explicit_origin <= cfg_data;
        REG_EXPL_WIDTH:  explicit_width  <= cfg_data;
        default: ;
      endcase
    end
  end

  // sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= ST_CLR;
      clr_addr      <= '0;
      weight_sum    <= '0;
      active_origin <= '0;
      active_width  <= VAL_W'(1);
      m_tvalid      <= 1'b0;
      div_req.start <= 1'b0;
    end else begin
      div_req.start <= 1'b0;
      // in ST_RD_OUT the valid flag is handled by that state
      if (m_tvalid && m_tready && state != ST_RD_OUT) begin
        m_tvalid <= 1'b0;
      end
      case (state)
        ST_CLR: begin
          clr_addr <= clr_addr + BIN_AW'(1);
          if (clr_addr == BIN_AW'(BIN_SLOTS - 1)) begin
            state <= ST_IDLE;
          end
        end
        ST_IDLE: begin
          if (s_tvalid) begin
            weight <= in_weight;
            rd_idx <= in_index;
            case (in_func)
              FUNC_CLEAR: begin
                weight_sum <= '0;
                clr_addr   <= '0;
                if (use_explicit) begin
                  active_origin <= explicit_origin;
                  active_width  <= (explicit_width == '0) ? VAL_W'(1) : explicit_width;
                  state         <= ST_CLR;
                end else begin
                  active_origin <= sample_min;
                  if (sample_max == sample_min) begin
                    active_width <= WIDTH_LARGE;
                    state        <= ST_CLR;
                  end else if (span[VAL_W]) begin
                    active_width <= VAL_W'(1);
                    state        <= ST_CLR;
                  end else begin
                    div_req.start    <= 1'b1;
                    div_req.dividend <= DIV_N'(span[VAL_W-1:0]);
                    div_req.divisor  <= DVS_W'(req_eff);
                    state            <= ST_SET_DIV;
                  end
                end
              end
              FUNC_ADD: begin
                if (offset[VAL_W]) begin
                  bin   <= '0;
                  state <= ST_ADD_RD;
                end else begin
                  div_req.start    <= 1'b1;
                  div_req.dividend <= DIV_N'(offset[VAL_W-1:0]);
                  div_req.divisor  <= DVS_W'(active_width);
                  state            <= ST_ADD_DIV;
                end
              end
              FUNC_READ: begin
                if (idx_in_store) begin
                  bin   <= BIN_AW'(in_index);
                  state <= ST_RD_RD;
                end else begin
                  // past the store: zero count, zero fraction
                  count <= '0;
                  state <= ST_RD_OUT;
                end
              end
              default: ;
            endcase
          end
        end
        ST_SET_DIV: begin
          if (div_rsp.done) begin
            active_width <= (div_rsp.quotient == '0) ? VAL_W'(1)
                                                     : div_rsp.quotient[VAL_W-1:0];
            state        <= ST_CLR;
          end
        end
        ST_ADD_DIV: begin
          if (div_rsp.done) begin
            bin   <= (div_rsp.quotient > DIV_N'(BIN_SLOTS - 1)) ? BIN_AW'(BIN_SLOTS - 1)
                                                                : div_rsp.quotient[BIN_AW-1:0];
            state <= ST_ADD_RD;
          end
        end
        ST_ADD_RD: state <= ST_ADD_WR;   // bin read in flight
        ST_ADD_WR: begin
          weight_sum <= tot_sum[CNT_W] ? CNT_MAX : tot_sum[CNT_W-1:0];
          state      <= ST_IDLE;
        end
        ST_RD_RD: state <= ST_RD_CNT;
        ST_RD_CNT: begin
          count <= ram_rdata;
          if (weight_sum == '0) begin
            state <= ST_RD_OUT;
          end else begin
            div_req.start    <= 1'b1;
            div_req.dividend <= {ram_rdata, {FRACTION_BITS{1'b0}}};
            div_req.divisor  <= weight_sum;
            state            <= ST_RD_DIV;
          end
        end
        ST_RD_DIV: begin
          if (div_rsp.done) begin
            state <= ST_RD_OUT;
          end
        end
        ST_RD_OUT: begin
          // hold until the output register is free
          if (!m_tvalid || m_tready) begin
            m_tvalid <= 1'b1;
            state    <= ST_IDLE;
          end
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

  // result fields
  logic [PROB_W-1:0] prob;

  always_ff @(posedge clk) begin
    if (state == ST_IDLE) begin
      prob <= '0;
    end else if (state == ST_RD_DIV && div_rsp.done) begin
      prob <= div_rsp.quotient[PROB_W-1:0];
    end
    if (state == ST_RD_OUT && (!m_tvalid || m_tready)) begin
      m_tdata <= {5'd0, prob, count, rd_idx};
      m_tuser <= (weight_sum == '0);
    end
  end

  // bin update is always the second half of a read-modify-write
  a_add_wr_after_rd: assert property (@(posedge clk) disable iff (rst)
    state == ST_ADD_WR |-> $past(state) == ST_ADD_RD)
    else $error("bin write without its read");

  // divider only answers while a divide is awaited
  a_div_done_state: assert property (@(posedge clk) disable iff (rst)
    div_rsp.done |-> (state == ST_SET_DIV || state == ST_ADD_DIV || state == ST_RD_DIV))
    else $error("divider result with no consumer");

  // bin width never zero
  a_width_nonzero: assert property (@(posedge clk) disable iff (rst)
    active_width != '0)
    else $error("zero bin width");

  // no input taken during the clearing sweep
  a_no_accept_clr: assert property (@(posedge clk) disable iff (rst)
    state == ST_CLR |-> !s_tready)
    else $error("word accepted during clear");

endmodule

// File: design/hbe_ram.sv
module hbe_ram #(
  parameter int DEPTH = 1024,
  parameter int WIDTH = 40,
  parameter int AW    = $clog2(DEPTH)
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// File: design/hbe_div.sv
module hbe_div (
  input  logic             clk,
  input  logic             rst,
  input  hbe_pkg::div_req_t req,
  output hbe_pkg::div_rsp_t rsp
);
  import hbe_pkg::*;

  localparam int STEP_W = $clog2(DIV_N + 1);

  logic              busy;
  logic [STEP_W-1:0] steps;
  logic [DVS_W-1:0]  rem;
  logic [DVS_W-1:0]  dvs;
  logic [DIV_N-1:0]  quo;
  logic              done;

  logic [DVS_W:0] trial;
  logic           ge;

  // restoring division, one quotient bit a cycle
  assign trial = {rem, quo[DIV_N-1]};
  assign ge    = trial >= {1'b0, dvs};

  always_ff @(posedge clk) begin
    if (rst) begin
      busy  <= 1'b0;
      done  <= 1'b0;
      steps <= '0;
    end else begin
      done <= 1'b0;
      if (req.start) begin
        busy  <= 1'b1;
        steps <= '0;
        rem   <= '0;
        dvs   <= req.divisor;
        quo   <= req.dividend;
      end else if (busy) begin
        rem   <= ge ? DVS_W'(trial - {1'b0, dvs}) : trial[DVS_W-1:0];
        quo   <= {quo[DIV_N-2:0], ge};
        steps <= steps + STEP_W'(1);
        if (steps == STEP_W'(DIV_N - 1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  assign rsp.done     = done;
  assign rsp.quotient = quo;

endmodule
